### rtl/lfr_pkg.sv
// lfr_pkg: shared types, constants and the crc step for the link frame receiver
// used by lfr_front, lfr_queue, lfr_drain and link_frame_receiver
`default_nettype none

package lfr_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam int CFG_AW = 4;

	localparam logic [7:0] FIRST_MARKER_RST   = 8'hAA;
	localparam logic [7:0] SECOND_MARKER_RST  = 8'h55;
	localparam logic [7:0] FORMAT_VERSION_RST = 8'h01;
	localparam logic [6:0] PAYLOAD_LIMIT_RST  = 7'd64;

	typedef enum logic [1:0] {
		REG_FIRST_MARKER   = 2'd0,
		REG_SECOND_MARKER  = 2'd1,
		REG_FORMAT_VERSION = 2'd2,
		REG_PAYLOAD_LIMIT  = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_MARK0   = 3'd0,
		PH_MARK1   = 3'd1,
		PH_HEADER  = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CRC     = 3'd4
	} phase_t;

	typedef enum logic {
		RK_GOOD      = 1'b0,
		RK_CRC_ERROR = 1'b1
	} result_kind_t;

	typedef enum logic [2:0] {
		HP_VERSION  = 3'd0,
		HP_TYPE     = 3'd1,
		HP_SEQ_LO   = 3'd2,
		HP_SEQ_HI   = 3'd3,
		HP_LEN_LO   = 3'd4,
		HP_LEN_HI   = 3'd5
	} hdr_pos_t;

	typedef struct packed {
		logic [7:0] first_marker;
		logic [7:0] second_marker;
		logic [7:0] format_version;
		logic [6:0] payload_limit;
	} cfg_t;

	// one finished frame handed from the front to the drain side
	typedef struct packed {
		result_kind_t kind;
		logic [7:0]   frame_type;
		logic [15:0]  sequence_number;
		logic [6:0]   payload_length;
		logic [31:0]  good_total;
		logic [31:0]  crc_error_total;
		logic [31:0]  resync_total;
	} desc_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### rtl/link_frame_receiver.sv
// link_frame_receiver: top level with the apb register file, front, queue and drain
// depends on lfr_pkg, lfr_front, lfr_queue, lfr_drain
//
// Usage:
//   rx channel: one received byte per item (rx_valid, rx_stall, rx_byte).
//   result channel: one item per payload byte of a good frame, one item for an
//   empty good frame, one item for a crc mismatch; counters ride on every item.
//   config: apb registers at 0x0 first_marker, 0x4 second_marker,
//   0x8 format_version, 0xC payload_limit; write only while the block is idle.
// Throughput: while rx_stall is low the front takes one byte per cycle. Payload
//   bytes of a new frame are held off while the drain still reads the previous
//   frame's payload from the payload memory; markers and header bytes keep flowing.
// Result path: after the last crc byte is taken, the frame item passes the queue,
//   the sequencer, the memory read and the output register; items then follow at
//   one per cycle while result_stall is low, and an idle gap separates the runs
//   of two queued frames.
// Reset: arst_n clears the parser to marker hunt, zeroes the counters, empties
//   the queue and restores register defaults; the payload memory is not cleared.
// Stall: result_stall holds the output register; the drain and then the queue
//   back up, and the front holds rx_stall on the final crc byte if the queue fills.
`default_nettype none

module link_frame_receiver import lfr_pkg::*; #(
	parameter int MAX_PAYLOAD = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  wire logic              rx_valid,
	output logic                   rx_stall,
	input  wire logic [7:0]        rx_byte,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic                   result_kind,
	output logic [7:0]             frame_type,
	output logic [15:0]            sequence_number,
	output logic [6:0]             payload_length,
	output logic [5:0]             byte_index,
	output logic [7:0]             payload_byte,
	output logic                   byte_valid,
	output logic                   last_of_frame,
	output logic [31:0]            good_frame_total,
	output logic [31:0]            crc_error_total,
	output logic [31:0]            resync_total
);

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	cfg_t          cfg_q;
	logic          cfg_wr;
	reg_idx_t      reg_idx;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          q_push, q_pop, q_full, q_empty, drain_done;
	desc_t         q_push_data, q_pop_data;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_marker   <= FIRST_MARKER_RST;
			cfg_q.second_marker  <= SECOND_MARKER_RST;
			cfg_q.format_version <= FORMAT_VERSION_RST;
			cfg_q.payload_limit  <= PAYLOAD_LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_FIRST_MARKER:   cfg_q.first_marker   <= pwdata[7:0];
				REG_SECOND_MARKER:  cfg_q.second_marker  <= pwdata[7:0];
				REG_FORMAT_VERSION: cfg_q.format_version <= pwdata[7:0];
				REG_PAYLOAD_LIMIT:  cfg_q.payload_limit  <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FIRST_MARKER:   prdata = {24'd0, cfg_q.first_marker};
			REG_SECOND_MARKER:  prdata = {24'd0, cfg_q.second_marker};
			REG_FORMAT_VERSION: prdata = {24'd0, cfg_q.format_version};
			REG_PAYLOAD_LIMIT:  prdata = {25'd0, cfg_q.payload_limit};
			default:            prdata = 32'd0;
		endcase
	end

	lfr_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.AW(AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_byte   (rx_byte),
		.rx_stall  (rx_stall),
		.cfg       (cfg_q),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.q_push    (q_push),
		.q_data    (q_push_data),
		.q_full    (q_full),
		.drain_done(drain_done)
	);

	lfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_push_data),
		.pop      (q_pop),
		.pop_data (q_pop_data),
		.full     (q_full),
		.empty    (q_empty)
	);

	lfr_drain #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.AW(AW)
	) u_drain (
		.clk             (clk),
		.arst_n          (arst_n),
		.mem_we          (mem_we),
		.mem_waddr       (mem_waddr),
		.mem_wdata       (mem_wdata),
		.q_empty         (q_empty),
		.q_data          (q_pop_data),
		.q_pop           (q_pop),
		.drain_done      (drain_done),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.result_kind     (result_kind),
		.frame_type      (frame_type),
		.sequence_number (sequence_number),
		.payload_length  (payload_length),
		.byte_index      (byte_index),
		.payload_byte    (payload_byte),
		.byte_valid      (byte_valid),
		.last_of_frame   (last_of_frame),
		.good_frame_total(good_frame_total),
		.crc_error_total (crc_error_total),
		.resync_total    (resync_total)
	);

endmodule

`default_nettype wire

### rtl/lfr_front.sv
// lfr_front: marker hunt, header parse, crc check and frame counters
// depends on lfr_pkg; writes payload bytes into the drain memory, pushes frame items to lfr_queue
`default_nettype none

module lfr_front import lfr_pkg::*; #(
	parameter int MAX_PAYLOAD = 64,
	parameter int AW = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rx_valid,
	input  wire logic [7:0]    rx_byte,
	output logic               rx_stall,
	input  wire cfg_t          cfg,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output logic [7:0]         mem_wdata,
	output logic               q_push,
	output desc_t              q_data,
	input  wire logic          q_full,
	input  wire logic          drain_done
);

	localparam logic [6:0] MAX_LEN = 7'(MAX_PAYLOAD);

	phase_t      phase_q, phase_d;
	logic [6:0]  pos_q, pos_d;
	logic [7:0]  type_q, type_d;
	logic [15:0] seq_q, seq_d;
	logic [6:0]  len_q, len_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_lo_q, crc_lo_d;
	logic        vbad_q, vbad_d;
	logic [7:0]  len_lo_q, len_lo_d;
	logic [31:0] good_q, good_d;
	logic [31:0] err_q, err_d;
	logic [31:0] resync_q, resync_d;
	logic        busy_q, busy_d;
	logic        accept;
	logic [6:0]  limit;
	logic [15:0] crc_next;

	assign limit    = (cfg.payload_limit > MAX_LEN) ? MAX_LEN : cfg.payload_limit;
	assign crc_next = crc16_byte(crc_q, rx_byte);

	// payload bytes wait while the drain reads the previous frame, the last crc byte on a full queue
	assign rx_stall = (phase_q == PH_PAYLOAD && busy_q) ||
		(phase_q == PH_CRC && pos_q != 7'd0 && q_full);
	assign accept = rx_valid && !rx_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MARK0;
			pos_q    <= '0;
			type_q   <= '0;
			seq_q    <= '0;
			len_q    <= '0;
			crc_q    <= CRC_INIT;
			crc_lo_q <= '0;
			vbad_q   <= 1'b0;
			len_lo_q <= '0;
			good_q   <= '0;
			err_q    <= '0;
			resync_q <= '0;
			busy_q   <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			type_q   <= type_d;
			seq_q    <= seq_d;
			len_q    <= len_d;
			crc_q    <= crc_d;
			crc_lo_q <= crc_lo_d;
			vbad_q   <= vbad_d;
			len_lo_q <= len_lo_d;
			good_q   <= good_d;
			err_q    <= err_d;
			resync_q <= resync_d;
			busy_q   <= busy_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		type_d    = type_q;
		seq_d     = seq_q;
		len_d     = len_q;
		crc_d     = crc_q;
		crc_lo_d  = crc_lo_q;
		vbad_d    = vbad_q;
		len_lo_d  = len_lo_q;
		good_d    = good_q;
		err_d     = err_q;
		resync_d  = resync_q;
		busy_d    = busy_q;
		mem_we    = 1'b0;
		mem_waddr = pos_q[AW-1:0];
		mem_wdata = rx_byte;
		q_push    = 1'b0;
		q_data.kind = RK_GOOD;
		if (drain_done) begin
			busy_d = 1'b0;
		end
		if (accept) begin
			unique case (phase_q)
				PH_MARK0: begin
					if (rx_byte == cfg.first_marker) begin
						phase_d = PH_MARK1;
						pos_d   = '0;
					end
				end
				PH_MARK1: begin
					if (rx_byte == cfg.second_marker) begin
						phase_d = PH_HEADER;
						pos_d   = '0;
						crc_d   = CRC_INIT;
					end else if (rx_byte != cfg.first_marker) begin
						resync_d = resync_q + 32'd1;
						phase_d  = PH_MARK0;
						pos_d    = '0;
					end
				end
				PH_HEADER: begin
					crc_d = crc_next;
					unique case (hdr_pos_t'(pos_q[2:0]))
						HP_VERSION: vbad_d   = (rx_byte != cfg.format_version);
						HP_TYPE:    type_d   = rx_byte;
						HP_SEQ_LO:  seq_d    = {seq_q[15:8], rx_byte};
						HP_SEQ_HI:  seq_d    = {rx_byte, seq_q[7:0]};
						HP_LEN_LO:  len_lo_d = rx_byte;
						default: ;
					endcase
					if (pos_q < 7'(HP_LEN_HI)) begin
						pos_d = pos_q + 7'd1;
					end else begin
						pos_d = '0;
						if (vbad_q || rx_byte != 8'd0 || len_lo_q > {1'b0, limit}) begin
							resync_d = resync_q + 32'd1;
							phase_d  = PH_MARK0;
						end else begin
							len_d   = len_lo_q[6:0];
							phase_d = (len_lo_q[6:0] != 7'd0) ? PH_PAYLOAD : PH_CRC;
						end
					end
				end
				PH_PAYLOAD: begin
					crc_d  = crc_next;
					mem_we = 1'b1;
					pos_d  = pos_q + 7'd1;
					if (pos_q + 7'd1 >= len_q) begin
						phase_d = PH_CRC;
						pos_d   = '0;
					end
				end
				PH_CRC: begin
					if (pos_q == 7'd0) begin
						crc_lo_d = rx_byte;
						pos_d    = 7'd1;
					end else begin
						phase_d = PH_MARK0;
						pos_d   = '0;
						q_push  = 1'b1;
						if ({rx_byte, crc_lo_q} != crc_q) begin
							err_d       = err_q + 32'd1;
							q_data.kind = RK_CRC_ERROR;
						end else begin
							good_d = good_q + 32'd1;
							if (len_q != 7'd0) begin
								busy_d = 1'b1;
							end
						end
					end
				end
				default: begin
					phase_d = PH_MARK0;
					pos_d   = '0;
				end
			endcase
		end
		q_data.frame_type      = type_q;
		q_data.sequence_number = seq_q;
		q_data.payload_length  = len_q;
		q_data.good_total      = good_d;
		q_data.crc_error_total = err_d;
		q_data.resync_total    = resync_d;
	end

endmodule

`default_nettype wire

### rtl/lfr_queue.sv
// lfr_queue: two-entry fifo of finished frame items between front and drain
// depends on lfr_pkg for desc_t
`default_nettype none

module lfr_queue import lfr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire desc_t push_data,
	input  wire logic  pop,
	output desc_t      pop_data,
	output logic       full,
	output logic       empty
);

	desc_t      entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

`default_nettype wire

### rtl/lfr_drain.sv
// lfr_drain: payload memory and result sequencer, one result item per cycle while result_stall is low
// depends on lfr_pkg; takes frame items from lfr_queue, memory is written by lfr_front
`default_nettype none

module lfr_drain import lfr_pkg::*; #(
	parameter int MAX_PAYLOAD = 64,
	parameter int AW = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          mem_we,
	input  wire logic [AW-1:0] mem_waddr,
	input  wire logic [7:0]    mem_wdata,
	input  wire logic          q_empty,
	input  wire desc_t         q_data,
	output logic               q_pop,
	output logic               drain_done,
	output logic               result_valid,
	input  wire logic          result_stall,
	output logic               result_kind,
	output logic [7:0]         frame_type,
	output logic [15:0]        sequence_number,
	output logic [6:0]         payload_length,
	output logic [5:0]         byte_index,
	output logic [7:0]         payload_byte,
	output logic               byte_valid,
	output logic               last_of_frame,
	output logic [31:0]        good_frame_total,
	output logic [31:0]        crc_error_total,
	output logic [31:0]        resync_total
);

	logic [7:0] mem [MAX_PAYLOAD];

	desc_t         cur_q;
	logic          cur_valid_q;
	logic [AW-1:0] idx_q;

	// stage 1 holds the registered memory read
	logic          valid_s1;
	desc_t         desc_s1;
	logic [AW-1:0] idx_s1;
	logic          bvalid_s1;
	logic          last_s1;
	logic [7:0]    rd_s1;

	logic out_valid_q;
	logic out_free, move_s1, free_s1, issue, issue_last, cur_is_mem;

	assign cur_is_mem = (cur_q.kind == RK_GOOD) && (cur_q.payload_length != 7'd0);
	assign issue_last = cur_is_mem ? (7'(idx_q) + 7'd1 == cur_q.payload_length) : 1'b1;
	assign out_free   = !out_valid_q || !result_stall;
	assign move_s1    = valid_s1 && out_free;
	assign free_s1    = !valid_s1 || move_s1;
	assign issue      = cur_valid_q && free_s1;
	assign q_pop      = !cur_valid_q && !q_empty;
	// last read of the stored payload is out, the front may refill it
	assign drain_done = issue && issue_last && cur_is_mem;

	assign result_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (issue) begin
			rd_s1 <= mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
		if (issue) begin
			desc_s1   <= cur_q;
			idx_s1    <= idx_q;
			bvalid_s1 <= cur_is_mem;
			last_s1   <= issue_last;
		end
		if (move_s1) begin
			result_kind      <= desc_s1.kind;
			frame_type       <= desc_s1.frame_type;
			sequence_number  <= desc_s1.sequence_number;
			payload_length   <= desc_s1.payload_length;
			byte_index       <= 6'(idx_s1);
			payload_byte     <= bvalid_s1 ? rd_s1 : 8'd0;
			byte_valid       <= bvalid_s1;
			last_of_frame    <= last_s1;
			good_frame_total <= desc_s1.good_total;
			crc_error_total  <= desc_s1.crc_error_total;
			resync_total     <= desc_s1.resync_total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (issue) begin
				if (issue_last) begin
					cur_valid_q <= 1'b0;
				end else begin
					idx_q <= idx_q + AW'(1);
				end
			end
			if (free_s1) begin
				valid_s1 <= issue;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/lfr_checker.sv
// lfr_checker: port-level checks on the result channel of link_frame_receiver
// bound to the top level below; imports no package
`default_nettype none

module lfr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic        result_kind,
	input wire logic [6:0]  payload_length,
	input wire logic [5:0]  byte_index,
	input wire logic [7:0]  payload_byte,
	input wire logic        byte_valid,
	input wire logic        last_of_frame
);

	// a held result item keeps its place and data
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(byte_index) &&
		$stable(payload_byte) && $stable(last_of_frame))
		else $error("stalled result item changed");

	// crc error and empty frame items stand alone at index zero
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !byte_valid |-> last_of_frame && byte_index == 6'd0 &&
		payload_byte == 8'd0)
		else $error("item without data is not a lone last item");

	a_error_nodata: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind |-> !byte_valid)
		else $error("crc error item carries payload");

	// the last data item sits at the end of the header length
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && byte_valid |->
		(last_of_frame == (7'(byte_index) + 7'd1 == payload_length)))
		else $error("last_of_frame does not match byte_index");

endmodule

bind link_frame_receiver lfr_checker u_lfr_checker (.*);

`default_nettype wire
